@@ sv/sm83_pkg.sv @@
// Shared types and constants for the SM83-style accumulator ALU.
// Holds the operation codes, the flag bit positions and the result bundle.
// No dependencies; used by sm83_alu_core and sm83_alu_with_flags.
package sm83_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_CP     = 5'd4,
    OP_AND    = 5'd5,
    OP_OR     = 5'd6,
    OP_XOR    = 5'd7,
    OP_CPL    = 5'd8,
    OP_INC    = 5'd9,
    OP_DEC    = 5'd10,
    OP_RL     = 5'd11,
    OP_RLC    = 5'd12,
    OP_RR     = 5'd13,
    OP_RRC    = 5'd14,
    OP_RLA    = 5'd15,
    OP_RLCA   = 5'd16,
    OP_RRA    = 5'd17,
    OP_RRCA   = 5'd18,
    OP_BIT    = 5'd19,
    OP_RES    = 5'd20,
    OP_SET    = 5'd21,
    OP_ADD_HL = 5'd22
  } op_t;

  // Flag bit positions inside the 4-bit flag word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [15:0] hl;
  } alu_result_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [15:0] hl;
  } alu_state_t;

endpackage

@@ sv/sm83_alu_core.sv @@
// Combinational datapath of the SM83-style ALU: one operation on the
// current accumulator, flags and HL. Depends on sm83_pkg.
module sm83_alu_core (
  input  logic [4:0]           func,
  input  logic [7:0]           operand,
  input  logic [2:0]           bit_index,
  input  logic [15:0]          operand_wide,
  input  sm83_pkg::alu_state_t state,
  output sm83_pkg::alu_result_t result
);

  logic [7:0]  acc;
  logic [3:0]  flg;
  logic        cin;
  logic        use_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_low;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_low;
  logic [7:0]  logic_and;
  logic [7:0]  logic_or;
  logic [7:0]  logic_xor;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [7:0]  rot_src;
  logic [7:0]  rot_left;
  logic [7:0]  rot_right;
  logic        rot_through;
  logic [7:0]  bit_mask;
  logic [16:0] hl_sum;
  logic [12:0] hl_low;

  assign acc     = state.acc;
  assign flg     = state.flags;
  assign cin     = flg[sm83_pkg::FLAG_C];
  assign use_cin = (func == sm83_pkg::OP_ADC) || (func == sm83_pkg::OP_SBC);

  assign add_sum  = {1'b0, acc} + {1'b0, operand} + {8'd0, use_cin & cin};
  assign add_low  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, use_cin & cin};
  // Borrow out of bit 8 or bit 4 is the carry or half-carry of a subtraction.
  assign sub_diff = {1'b0, acc} - {1'b0, operand} - {8'd0, use_cin & cin};
  assign sub_low  = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, use_cin & cin};

  assign logic_and = acc & operand;
  assign logic_or  = acc | operand;
  assign logic_xor = acc ^ operand;
  assign inc_val   = operand + 8'd1;
  assign dec_val   = operand - 8'd1;

  // Accumulator rotates share the rotator with the register rotates.
  assign rot_src = (func == sm83_pkg::OP_RLA || func == sm83_pkg::OP_RLCA ||
                    func == sm83_pkg::OP_RRA || func == sm83_pkg::OP_RRCA) ? acc : operand;
  assign rot_through = (func == sm83_pkg::OP_RL || func == sm83_pkg::OP_RR ||
                        func == sm83_pkg::OP_RLA || func == sm83_pkg::OP_RRA);
  assign rot_left  = {rot_src[6:0], rot_through ? cin : rot_src[7]};
  assign rot_right = {rot_through ? cin : rot_src[0], rot_src[7:1]};

  assign bit_mask = 8'd1 << bit_index;

  assign hl_sum = {1'b0, state.hl} + {1'b0, operand_wide};
  assign hl_low = {1'b0, state.hl[11:0]} + {1'b0, operand_wide[11:0]};

  always_comb begin
    result.value = 8'd0;
    result.acc   = acc;
    result.flags = flg;
    result.hl    = state.hl;
    unique case (func)
      sm83_pkg::OP_ADD, sm83_pkg::OP_ADC: begin
        result.acc   = add_sum[7:0];
        result.flags = {add_sum[7:0] == 8'd0, 1'b0, add_low[4], add_sum[8]};
      end
      sm83_pkg::OP_SUB, sm83_pkg::OP_SBC: begin
        result.acc   = sub_diff[7:0];
        result.flags = {sub_diff[7:0] == 8'd0, 1'b1, sub_low[4], sub_diff[8]};
      end
      sm83_pkg::OP_CP: begin
        result.flags = {sub_diff[7:0] == 8'd0, 1'b1, sub_low[4], sub_diff[8]};
      end
      sm83_pkg::OP_AND: begin
        result.acc   = logic_and;
        result.flags = {logic_and == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      sm83_pkg::OP_OR: begin
        result.acc   = logic_or;
        result.flags = {logic_or == 8'd0, 3'b000};
      end
      sm83_pkg::OP_XOR: begin
        result.acc   = logic_xor;
        result.flags = {logic_xor == 8'd0, 3'b000};
      end
      sm83_pkg::OP_CPL: begin
        result.acc   = ~acc;
        result.flags = {flg[sm83_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      sm83_pkg::OP_INC: begin
        result.value = inc_val;
        result.flags = {inc_val == 8'd0, 1'b0, operand[3:0] == 4'hF, cin};
      end
      sm83_pkg::OP_DEC: begin
        result.value = dec_val;
        result.flags = {dec_val == 8'd0, 1'b1, operand[3:0] == 4'h0, cin};
      end
      sm83_pkg::OP_RL, sm83_pkg::OP_RLC: begin
        result.value = rot_left;
        result.flags = {rot_left == 8'd0, 2'b00, rot_src[7]};
      end
      sm83_pkg::OP_RR, sm83_pkg::OP_RRC: begin
        result.value = rot_right;
        result.flags = {rot_right == 8'd0, 2'b00, rot_src[0]};
      end
      sm83_pkg::OP_RLA, sm83_pkg::OP_RLCA: begin
        result.value = rot_left;
        result.acc   = rot_left;
        result.flags = {3'b000, rot_src[7]};
      end
      sm83_pkg::OP_RRA, sm83_pkg::OP_RRCA: begin
        result.value = rot_right;
        result.acc   = rot_right;
        result.flags = {3'b000, rot_src[0]};
      end
      sm83_pkg::OP_BIT: begin
        result.flags = {(operand & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      sm83_pkg::OP_RES: begin
        result.value = operand & ~bit_mask;
      end
      sm83_pkg::OP_SET: begin
        result.value = operand | bit_mask;
      end
      sm83_pkg::OP_ADD_HL: begin
        result.hl    = hl_sum[15:0];
        result.flags = {flg[sm83_pkg::FLAG_Z], 1'b0, hl_low[12], hl_sum[16]};
      end
      // Unused codes leave the state as it is.
      default: begin
        result.value = 8'd0;
      end
    endcase
  end

endmodule

@@ sv/sm83_alu_with_flags.sv @@
// Top level of the SM83-style ALU: architectural state, input handshake and
// the registered result beat. Depends on sm83_pkg and sm83_alu_core.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   input   | in_valid/in_ready  | func, operand, bit_index, operand_wide
//   output  | out_valid/out_ready| value_out, accumulator_out, flags_out, hl_out
//
// One beat per cycle unless stalled: each input beat is worked in a single
// pass of the core and its result is in the output register on the next cycle.
// Accumulator, flags and HL update at the accepting edge, so the next beat
// sees them at once. in_ready drops only while a result waits unaccepted.
// rst clears the state and the output valid.
module sm83_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  func,
  input  logic [7:0]  operand,
  input  logic [2:0]  bit_index,
  input  logic [15:0] operand_wide,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  value_out,
  output logic [7:0]  accumulator_out,
  output logic [3:0]  flags_out,
  output logic [15:0] hl_out
);

  sm83_pkg::alu_state_t  state;
  sm83_pkg::alu_result_t result;
  logic                  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  sm83_alu_core u_core (
    .func         (func),
    .operand      (operand),
    .bit_index    (bit_index),
    .operand_wide (operand_wide),
    .state        (state),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state.acc   <= result.acc;
        state.flags <= result.flags;
        state.hl    <= result.hl;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out       <= result.value;
      accumulator_out <= result.acc;
      flags_out       <= result.flags;
      hl_out          <= result.hl;
    end
  end

  // A waiting result must block new beats.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state))
    else $error("state changed without an accepted beat");

  // The shown result always matches the live state it left behind.
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accumulator_out == state.acc) && (flags_out == state.flags) &&
                  (hl_out == state.hl))
    else $error("result out of step with state");

endmodule
